// ===== rtl/lge_pkg.sv =====
// Shared types and constants for the Life generation engine.
// No dependencies; imported by the top level, the row update unit and the checker.
`default_nettype none

package lge_pkg;

	// default grid bounds
	localparam int DEF_MAX_ROWS = 64;
	localparam int DEF_MAX_COLS = 128;

	// field widths
	localparam int OP_W      = 2;
	localparam int ROW_W     = 6;
	localparam int COL_W     = 7;
	localparam int S_TDATA_W = 16;
	localparam int M_TDATA_W = 8;

	// configuration port
	localparam int PADDR_W  = 3;
	localparam int PDATA_W  = 32;
	localparam int AROWS_W  = 7;
	localparam int ACOLS_W  = 8;
	localparam logic [AROWS_W-1:0] AROWS_RST = 7'd49;
	localparam logic [ACOLS_W-1:0] ACOLS_RST = 8'd105;

	// B3/S23 neighbor counts
	localparam logic [3:0] SURVIVE_LO = 4'd2;
	localparam logic [3:0] BIRTH_CNT  = 4'd3;

	typedef enum logic [OP_W-1:0] {
		OP_CLEAR = 2'd0,
		OP_WRITE = 2'd1,
		OP_READ  = 2'd2,
		OP_STEP  = 2'd3
	} op_t;

	typedef enum logic {
		REG_ACTIVE_ROWS = 1'b0,
		REG_ACTIVE_COLS = 1'b1
	} reg_idx_t;

endpackage

`default_nettype wire

// ===== rtl/lge_row_calc.sv =====
// Row update unit: next generation of one grid row from the rows above and below.
// Columns wrap at the active column count. Depends on lge_pkg.
`default_nettype none

module lge_row_calc #(
	parameter int MAX_COLS = lge_pkg::DEF_MAX_COLS
) (
	input  wire logic [MAX_COLS-1:0]             up_row,
	input  wire logic [MAX_COLS-1:0]             mid_row,
	input  wire logic [MAX_COLS-1:0]             dn_row,
	input  wire logic [$clog2(MAX_COLS+1)-1:0]   ncols,
	output logic      [MAX_COLS-1:0]             new_row
);
	import lge_pkg::*;

	localparam int CAW = $clog2(MAX_COLS);

	logic [CAW-1:0] last_idx;
	logic           up_last, mid_last, dn_last;

	assign last_idx = CAW'(ncols - 1'b1);
	assign up_last  = up_row[last_idx];
	assign mid_last = mid_row[last_idx];
	assign dn_last  = dn_row[last_idx];

	for (genvar c = 0; c < MAX_COLS; c++) begin : g_col
		logic       ul, ml, dl, ur, mr, dr;
		logic [3:0] n;

		if (c == 0) begin : g_left_wrap
			assign ul = up_last;
			assign ml = mid_last;
			assign dl = dn_last;
		end else begin : g_left
			assign ul = up_row[c-1];
			assign ml = mid_row[c-1];
			assign dl = dn_row[c-1];
		end

		if (c == MAX_COLS-1) begin : g_right_wrap
			assign ur = up_row[0];
			assign mr = mid_row[0];
			assign dr = dn_row[0];
		end else begin : g_right
			logic is_last;

			assign is_last = (32'(c) == 32'(ncols) - 32'd1);
			assign ur = is_last ? up_row[0]  : up_row[c+1];
			assign mr = is_last ? mid_row[0] : mid_row[c+1];
			assign dr = is_last ? dn_row[0]  : dn_row[c+1];
		end

		assign n = 4'(ul) + 4'(up_row[c]) + 4'(ur) + 4'(ml) + 4'(mr)
			+ 4'(dl) + 4'(dn_row[c]) + 4'(dr);

		// columns past the active width stay dead
		assign new_row[c] = (32'(c) < 32'(ncols)) &&
			(mid_row[c] ? (n == SURVIVE_LO || n == BIRTH_CNT) : (n == BIRTH_CNT));
	end

endmodule

`default_nettype wire

// ===== rtl/life_generation_engine.sv =====
// Life generation engine, B3/S23 on a torus, grid held one row per memory word.
// Cell write/read: the row is read, then the cell is written back or sampled. Clear: zeros to every row.
// Step: one row read, updated and written back per cycle.
// One item is processed at a time; the next is taken while a result waits.
// Reset: a clearing pass over every grid memory row, no items taken.
// Depends on lge_pkg and lge_row_calc.
`default_nettype none

module life_generation_engine #(
	parameter int MAX_ROWS = lge_pkg::DEF_MAX_ROWS,
	parameter int MAX_COLS = lge_pkg::DEF_MAX_COLS
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	// input stream
	input  wire logic                           s_tvalid,
	output logic                                s_tready,
	input  wire logic [lge_pkg::S_TDATA_W-1:0]  s_tdata,  // row[5:0], col[12:6], cell_in[13], 0
	input  wire logic [lge_pkg::OP_W-1:0]       s_tuser,  // op[1:0]
	// result stream
	output logic                                m_tvalid,
	input  wire logic                           m_tready,
	output logic      [lge_pkg::M_TDATA_W-1:0]  m_tdata,  // cell_out[0], 0
	output logic                                m_tuser,  // step_done[0]
	// configuration
	input  wire logic                           psel,
	input  wire logic                           penable,
	input  wire logic                           pwrite,
	input  wire logic [lge_pkg::PADDR_W-1:0]    paddr,
	input  wire logic [lge_pkg::PDATA_W-1:0]    pwdata,
	output logic      [lge_pkg::PDATA_W-1:0]    prdata,
	output logic                                pready
);
	import lge_pkg::*;

	localparam int RAW = $clog2(MAX_ROWS);
	localparam int CAW = $clog2(MAX_COLS);
	localparam int RCW = $clog2(MAX_ROWS+1);
	localparam int CCW = $clog2(MAX_COLS+1);

	typedef enum logic [3:0] {
		ST_INIT, ST_IDLE, ST_CLEAR, ST_CELL,
		ST_PRIME1, ST_PRIME2, ST_SWEEP, ST_FINISH
	} state_t;

	state_t state_q;

	logic [AROWS_W-1:0] active_rows_q;
	logic [ACOLS_W-1:0] active_cols_q;
	logic [RCW-1:0]     eff_rows;
	logic [CCW-1:0]     eff_cols;

	logic [RAW-1:0]     r_q;
	logic               r_last;
	logic               m_tvalid_q, m_cell_q, m_done_q;
	logic               res_cell_q, res_done_q;

	op_t                op_q;
	logic [COL_W-1:0]   col_q;
	logic               cell_in_q, inside_q;
	logic [RAW-1:0]     rd_addr_hold_q;

	logic [MAX_COLS-1:0] grid_mem [MAX_ROWS];
	logic [MAX_COLS-1:0] rd_data_q;
	logic                rd_en, wr_en;
	logic [RAW-1:0]      rd_addr, wr_addr;
	logic [MAX_COLS-1:0] wr_data;

	logic [MAX_COLS-1:0] up_q, cur_q, first_q, down_row, new_row;

	logic               accept;
	op_t                in_op;
	logic [ROW_W-1:0]   in_row;
	logic [COL_W-1:0]   in_col;
	logic               in_cell, in_inside;
	logic [CAW-1:0]     col_idx;
	logic               sweep_active;

	// ---------------- configuration port ----------------
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_rows_q <= AROWS_RST;
			active_cols_q <= ACOLS_RST;
		end else if (psel && penable && pwrite && pready) begin
			case (reg_idx_t'(paddr[2]))
				REG_ACTIVE_ROWS: active_rows_q <= pwdata[AROWS_W-1:0];
				REG_ACTIVE_COLS: active_cols_q <= pwdata[ACOLS_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx_t'(paddr[2]))
			REG_ACTIVE_ROWS: prdata = PDATA_W'(active_rows_q);
			REG_ACTIVE_COLS: prdata = PDATA_W'(active_cols_q);
			default:         prdata = '0;
		endcase
	end

	// saturate the torus size into [3, MAX]
	always_comb begin
		if (32'(active_rows_q) < 32'd3)
			eff_rows = RCW'(3);
		else if (32'(active_rows_q) > 32'(MAX_ROWS))
			eff_rows = RCW'(MAX_ROWS);
		else
			eff_rows = RCW'(active_rows_q);

		if (32'(active_cols_q) < 32'd3)
			eff_cols = CCW'(3);
		else if (32'(active_cols_q) > 32'(MAX_COLS))
			eff_cols = CCW'(MAX_COLS);
		else
			eff_cols = CCW'(active_cols_q);
	end

	// ---------------- input decode ----------------
	assign s_tready  = (state_q == ST_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign in_op     = op_t'(s_tuser);
	assign in_row    = s_tdata[ROW_W-1:0];
	assign in_col    = s_tdata[ROW_W+COL_W-1:ROW_W];
	assign in_cell   = s_tdata[ROW_W+COL_W];
	assign in_inside = (32'(in_row) < 32'(eff_rows)) && (32'(in_col) < 32'(eff_cols));
	assign col_idx   = CAW'(col_q);

	assign r_last       = (r_q == RAW'(MAX_ROWS-1));
	assign sweep_active = (32'(r_q) < 32'(eff_rows));
	assign down_row     = (32'(r_q) == 32'(eff_rows) - 32'd1) ? first_q : rd_data_q;

	lge_row_calc #(
		.MAX_COLS (MAX_COLS)
	) u_row_calc (
		.up_row  (up_q),
		.mid_row (cur_q),
		.dn_row  (down_row),
		.ncols   (eff_cols),
		.new_row (new_row)
	);

	// ---------------- memory port control ----------------
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = '0;
		wr_en   = 1'b0;
		wr_addr = r_q;
		wr_data = '0;
		case (state_q)
			ST_IDLE: begin
				rd_en   = accept;
				rd_addr = (in_op == OP_STEP) ? RAW'(32'(eff_rows) - 32'd1) : RAW'(in_row);
			end
			ST_INIT, ST_CLEAR: begin
				wr_en = 1'b1;
			end
			ST_CELL: begin
				wr_en            = (op_q == OP_WRITE) && inside_q;
				wr_addr          = rd_addr_hold_q;
				wr_data          = rd_data_q;
				wr_data[col_idx] = cell_in_q;
			end
			ST_PRIME1: begin
				rd_en   = 1'b1;
				rd_addr = RAW'(0);
			end
			ST_PRIME2: begin
				rd_en   = 1'b1;
				rd_addr = RAW'(1);
			end
			ST_SWEEP: begin
				rd_en   = (32'(r_q) + 32'd2 < 32'(eff_rows));
				rd_addr = RAW'(32'(r_q) + 32'd2);
				wr_en   = 1'b1;
				wr_data = sweep_active ? new_row : '0;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			grid_mem[wr_addr] <= wr_data;
		if (rd_en)
			rd_data_q <= grid_mem[rd_addr];
	end

	// ---------------- datapath registers ----------------
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q           <= in_op;
			col_q          <= in_col;
			cell_in_q      <= in_cell;
			inside_q       <= in_inside;
			rd_addr_hold_q <= RAW'(in_row);
		end
		case (state_q)
			ST_PRIME1: up_q <= rd_data_q;
			ST_PRIME2: begin
				cur_q   <= rd_data_q;
				first_q <= rd_data_q;
			end
			ST_SWEEP: begin
				up_q  <= cur_q;
				cur_q <= down_row;
			end
			default: ;
		endcase
	end

	// ---------------- sequencer and result register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_INIT;
			r_q        <= '0;
			res_cell_q <= 1'b0;
			res_done_q <= 1'b0;
			m_tvalid_q <= 1'b0;
			m_cell_q   <= 1'b0;
			m_done_q   <= 1'b0;
		end else begin
			// drop a taken word; FINISH reloads the register on its own
			if (m_tvalid_q && m_tready && state_q != ST_FINISH)
				m_tvalid_q <= 1'b0;

			case (state_q)
				ST_INIT: begin
					if (r_last) begin
						r_q     <= '0;
						state_q <= ST_IDLE;
					end else begin
						r_q <= r_q + 1'b1;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						r_q <= '0;
						case (in_op)
							OP_CLEAR:          state_q <= ST_CLEAR;
							OP_WRITE, OP_READ: state_q <= ST_CELL;
							OP_STEP:           state_q <= ST_PRIME1;
							default:           state_q <= ST_IDLE;
						endcase
					end
				end
				ST_CLEAR: begin
					if (r_last) begin
						r_q        <= '0;
						res_cell_q <= 1'b0;
						res_done_q <= 1'b0;
						state_q    <= ST_FINISH;
					end else begin
						r_q <= r_q + 1'b1;
					end
				end
				ST_CELL: begin
					res_cell_q <= (op_q == OP_READ) && inside_q && rd_data_q[col_idx];
					res_done_q <= 1'b0;
					state_q    <= ST_FINISH;
				end
				ST_PRIME1: state_q <= ST_PRIME2;
				ST_PRIME2: begin
					r_q     <= '0;
					state_q <= ST_SWEEP;
				end
				ST_SWEEP: begin
					if (r_last) begin
						r_q        <= '0;
						res_cell_q <= 1'b0;
						res_done_q <= 1'b1;
						state_q    <= ST_FINISH;
					end else begin
						r_q <= r_q + 1'b1;
					end
				end
				ST_FINISH: begin
					// hold until the result register is free
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_cell_q   <= res_cell_q;
						m_done_q   <= res_done_q;
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = M_TDATA_W'(m_cell_q);
	assign m_tuser  = m_done_q;

endmodule

`default_nettype wire

// ===== rtl/lge_checker.sv =====
// Port-level checker for the Life generation engine, bound to the top level.
// Depends on lge_pkg and on life_generation_engine's port names.
`default_nettype none

module lge_checker (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           s_tvalid,
	input  wire logic                           s_tready,
	input  wire logic                           m_tvalid,
	input  wire logic                           m_tready,
	input  wire logic [lge_pkg::M_TDATA_W-1:0]  m_tdata,
	input  wire logic                           m_tuser
);
	import lge_pkg::*;

	// words accepted at the input whose result is not yet taken
	logic [1:0] pending_q;
	logic       s_acc, m_acc;

	assign s_acc = s_tvalid && s_tready;
	assign m_acc = m_tvalid && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			pending_q <= '0;
		else if (s_acc && !m_acc)
			pending_q <= pending_q + 1'b1;
		else if (m_acc && !s_acc)
			pending_q <= pending_q - 1'b1;
	end

	a_no_invented_result: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> pending_q != 2'd0)
		else $error("result shown with no accepted word outstanding");

	a_bounded_inflight: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q != 2'd3)
		else $error("more than two words in flight");

	a_step_has_no_cell: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tuser && m_tdata[0]) && m_tdata[M_TDATA_W-1:1] == '0)
		else $error("step result carries cell data or padding is nonzero");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result changed");

endmodule

bind life_generation_engine lge_checker u_lge_checker (.*);

`default_nettype wire

// ===== test/life_generation_engine_check.sv =====
// Checker for the Life generation engine: keeps its own copy of the cell grid and sizes,
// predicts one result word per accepted input word and compares results in order.
// Depends on lge_pkg; watches the DUT ports only.
`default_nettype none

module life_generation_engine_check (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            s_tvalid,
	input  wire logic                            s_tready,
	input  wire logic [lge_pkg::S_TDATA_W-1:0]   s_tdata,  // row[5:0], col[12:6], cell_in[13], 0
	input  wire logic [lge_pkg::OP_W-1:0]        s_tuser,  // op[1:0]
	input  wire logic                            m_tvalid,
	input  wire logic                            m_tready,
	input  wire logic [lge_pkg::M_TDATA_W-1:0]   m_tdata,  // cell_out[0], 0
	input  wire logic                            m_tuser,  // step_done[0]
	input  wire logic                            psel,
	input  wire logic                            penable,
	input  wire logic                            pwrite,
	input  wire logic [lge_pkg::PADDR_W-1:0]     paddr,
	input  wire logic [lge_pkg::PDATA_W-1:0]     pwdata,
	input  wire logic                            pready,
	output int                                   fails,
	output int                                   pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import lge_pkg::*;

	localparam int NROWS = DEF_MAX_ROWS;
	localparam int NCOLS = DEF_MAX_COLS;

	typedef struct packed {
		logic cell_out;
		logic step_done;
	} life_result_t;

	logic [NCOLS-1:0]   life_grid [NROWS];
	logic [AROWS_W-1:0] rows_reg;
	logic [ACOLS_W-1:0] cols_reg;
	life_result_t       awaited [$];

	initial begin
		fails = 0;
		pending <= 0;
	end

	task automatic report(string what);
		$display("%0t ns: mismatch: %s", $realtime, what);
		fails++;
	endtask

	function automatic int rows_in_use();
		int r;
		r = int'(rows_reg);
		if (r < 3) r = 3;
		if (r > NROWS) r = NROWS;
		return r;
	endfunction

	function automatic int cols_in_use();
		int c;
		c = int'(cols_reg);
		if (c < 3) c = 3;
		if (c > NCOLS) c = NCOLS;
		return c;
	endfunction

	// B3/S23 over the wrapped active area; everything outside it ends up dead
	function automatic void advance_generation();
		logic [NCOLS-1:0] fresh [NROWS];
		int nr, nc, up, dn, lf, rt, n;
		nr = rows_in_use();
		nc = cols_in_use();
		for (int r = 0; r < NROWS; r++) fresh[r] = '0;
		for (int r = 0; r < nr; r++) begin
			up = (r + nr - 1) % nr;
			dn = (r + 1) % nr;
			for (int c = 0; c < nc; c++) begin
				lf = (c + nc - 1) % nc;
				rt = (c + 1) % nc;
				n = int'(life_grid[up][lf]) + int'(life_grid[up][c]) + int'(life_grid[up][rt])
					+ int'(life_grid[r][lf]) + int'(life_grid[r][rt])
					+ int'(life_grid[dn][lf]) + int'(life_grid[dn][c]) + int'(life_grid[dn][rt]);
				if (life_grid[r][c])
					fresh[r][c] = (n == 2 || n == 3);
				else
					fresh[r][c] = (n == 3);
			end
		end
		for (int r = 0; r < NROWS; r++) life_grid[r] = fresh[r];
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		life_result_t     want;
		op_t              op;
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
		logic             val;
		logic             in_area;
		if (!arst_n) begin
			for (int r = 0; r < NROWS; r++) life_grid[r] = '0;
			rows_reg = AROWS_RST;
			cols_reg = ACOLS_RST;
			awaited.delete();
			pending <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (awaited.size() == 0) begin
					report("result word with no item outstanding");
				end else begin
					want = awaited.pop_front();
					if (m_tdata[0] !== want.cell_out)
						report($sformatf("cell_out %b, expected %b", m_tdata[0], want.cell_out));
					if (m_tuser !== want.step_done)
						report($sformatf("step_done %b, expected %b", m_tuser, want.step_done));
				end
			end
			if (psel && penable && pwrite && pready) begin
				case (reg_idx_t'(paddr[2]))
					REG_ACTIVE_ROWS: rows_reg = pwdata[AROWS_W-1:0];
					REG_ACTIVE_COLS: cols_reg = pwdata[ACOLS_W-1:0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready) begin
				op = op_t'(s_tuser);
				row = s_tdata[ROW_W-1:0];
				col = s_tdata[ROW_W +: COL_W];
				val = s_tdata[ROW_W + COL_W];
				in_area = (int'(row) < rows_in_use()) && (int'(col) < cols_in_use());
				want = '0;
				case (op)
					OP_CLEAR: for (int r = 0; r < NROWS; r++) life_grid[r] = '0;
					OP_WRITE: if (in_area) life_grid[row][col] = val;
					OP_READ:  if (in_area) want.cell_out = life_grid[row][col];
					OP_STEP: begin
						advance_generation();
						want.step_done = 1'b1;
					end
					default: ;
				endcase
				awaited.push_back(want);
			end
			pending <= awaited.size();
		end
	end

endmodule

`default_nettype wire

// ===== test/life_generation_engine_test.sv =====
// Top of the Life generation engine bench: clock, reset, register writes, input words
// and result back-pressure; the checker beside the DUT predicts and compares.
// Depends on lge_pkg, life_generation_engine and life_generation_engine_check.
`default_nettype none

module life_generation_engine_test;
	timeunit 1ns;
	timeprecision 1ps;
	import lge_pkg::*;

	localparam int ITEM_TARGET = 1220;
	localparam int LONG_STALL  = 600;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata = '0;  // row[5:0], col[12:6], cell_in[13], 0
	logic [OP_W-1:0]      s_tuser = '0;  // op[1:0]
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;       // cell_out[0], 0
	logic                 m_tuser;       // step_done[0]
	logic                 psel = 1'b0;
	logic                 penable = 1'b0;
	logic                 pwrite = 1'b0;
	logic [PADDR_W-1:0]   paddr = '0;
	logic [PDATA_W-1:0]   pwdata = '0;
	logic [PDATA_W-1:0]   prdata;
	logic                 pready;
	int                   fails;
	int                   pending;

	int   items_sent = 0;
	int   grid_rows = int'(AROWS_RST);
	int   grid_cols = int'(ACOLS_RST);
	logic quiet = 1'b0;

	life_generation_engine DUT (.*);

	life_generation_engine_check watch (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#20_000_000;
		$display("FAILURE");
		$finish;
	end

	function automatic int pick_gap();
		int roll;
		if (quiet) return 0;
		roll = $urandom_range(0, 99);
		if (roll < 55) return 0;
		if (roll < 90) return $urandom_range(1, 3);
		return $urandom_range(8, 60);
	endfunction

	function automatic int clamp_size(int v, int hi);
		if (v < 3) return 3;
		if (v > hi) return hi;
		return v;
	endfunction

	// result side: random ready pattern, plus one long hold-off to back the block up
	initial begin : drain
		int hold, run;
		logic stalled;
		hold = 0;
		run = 0;
		stalled = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!stalled && items_sent >= 300) begin
				stalled = 1'b1;
				hold = LONG_STALL;
				run = 0;
			end
			if (hold > 0) begin
				hold--;
				m_tready <= 1'b0;
			end else if (run > 0) begin
				run--;
				m_tready <= 1'b1;
			end else begin
				run = $urandom_range(0, 40);
				hold = pick_gap();
				m_tready <= 1'b1;
			end
		end
	end

	task automatic write_reg(reg_idx_t idx, logic [PDATA_W-1:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= PADDR_W'(4 * int'(idx));
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic send_word(op_t op, int row, int col, int val);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {2'b00, 1'(val), 7'(col), 6'(row)};
		s_tuser <= op;
		do @(posedge clk); while (!s_tready);
		items_sent++;
	endtask

	// drop valid and hold until every outstanding result has been taken
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	task automatic send_noise();
		send_word(op_t'($urandom_range(0, 3)), $urandom_range(0, 63), $urandom_range(0, 127),
			$urandom_range(0, 1));
	endtask

	task automatic run_phase(int rows_val, int cols_val);
		logic [PDATA_W-1:0] hi_bits;
		int r0, c0, span;
		hi_bits = $urandom_range(0, 1) ? PDATA_W'($urandom()) : '0;
		write_reg(REG_ACTIVE_ROWS, (hi_bits & ~PDATA_W'(32'h7F)) | PDATA_W'(rows_val));
		write_reg(REG_ACTIVE_COLS, (hi_bits & ~PDATA_W'(32'hFF)) | PDATA_W'(cols_val));
		grid_rows = clamp_size(rows_val, DEF_MAX_ROWS);
		grid_cols = clamp_size(cols_val, DEF_MAX_COLS);
		quiet = ($urandom_range(0, 3) == 0);
		send_word(OP_CLEAR, $urandom_range(0, 63), $urandom_range(0, 127), $urandom_range(0, 1));
		// seed a random soup in a window that may straddle the wrap
		r0 = $urandom_range(0, grid_rows - 1);
		c0 = $urandom_range(0, grid_cols - 1);
		span = $urandom_range(4, 7);
		for (int i = 0; i < span * span; i++)
			send_word(OP_WRITE, (r0 + i / span) % grid_rows, (c0 + i % span) % grid_cols,
				$urandom_range(0, 1));
		repeat ($urandom_range(1, 5)) begin
			send_word(OP_STEP, $urandom_range(0, 63), $urandom_range(0, 127),
				$urandom_range(0, 1));
			repeat ($urandom_range(6, 14))
				send_word(OP_READ, (r0 + grid_rows - 2 + $urandom_range(0, span + 3)) % grid_rows,
					(c0 + grid_cols - 2 + $urandom_range(0, span + 3)) % grid_cols,
					$urandom_range(0, 1));
			if ($urandom_range(0, 2) == 0) send_noise();
		end
		wait_idle();
	endtask

	initial begin : stimulus
		int rows_set [10] = '{3, 0, 127, 64, 2, 65, 5, 64, 49, 1};
		int cols_set [10] = '{3, 0, 255, 128, 130, 3, 128, 4, 105, 7};
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset sizes 49 x 105: corners, an ignored write outside, clear
		send_word(OP_READ, 0, 0, 0);
		send_word(OP_WRITE, 0, 0, 1);
		send_word(OP_WRITE, 48, 104, 1);
		send_word(OP_WRITE, 63, 127, 1);
		send_word(OP_READ, 48, 104, 0);
		send_word(OP_READ, 63, 127, 1);
		send_word(OP_READ, 0, 0, 0);
		send_word(OP_CLEAR, 63, 127, 1);
		send_word(OP_READ, 0, 0, 0);
		send_word(OP_READ, 48, 104, 0);
		// blinker across the column seam; it flips across the row seam
		send_word(OP_WRITE, 0, 104, 1);
		send_word(OP_WRITE, 0, 0, 1);
		send_word(OP_WRITE, 0, 1, 1);
		send_word(OP_STEP, 0, 0, 0);
		send_word(OP_READ, 48, 0, 0);
		send_word(OP_READ, 0, 0, 0);
		send_word(OP_READ, 1, 0, 0);
		send_word(OP_READ, 0, 1, 0);
		send_word(OP_READ, 0, 104, 0);
		send_word(OP_STEP, 63, 127, 1);
		send_word(OP_READ, 0, 104, 0);
		send_word(OP_READ, 48, 0, 0);
		wait_idle();

		for (int i = 0; i < 10; i++) run_phase(rows_set[i], cols_set[i]);
		while (items_sent < ITEM_TARGET) begin
			if ($urandom_range(0, 2) == 0)
				run_phase($urandom_range(0, 127), $urandom_range(0, 255));
			else
				run_phase($urandom_range(3, 10), $urandom_range(3, 12));
		end

		wait_idle();
		repeat (DEF_MAX_ROWS + 8) @(posedge clk);
		if (fails == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

`default_nettype wire

// ===== sim.f =====
rtl/lge_pkg.sv
rtl/lge_row_calc.sv
rtl/life_generation_engine.sv
rtl/lge_checker.sv
test/life_generation_engine_check.sv
test/life_generation_engine_test.sv
